// File: design/rpa_pkg.sv
// Shared types and constants for the Radon projection accumulator.
package rpa_pkg;

    localparam int MAX_ROWS_DEF   = 256;
    localparam int MAX_COLS_DEF   = 256;
    localparam int MAX_ANGLES_DEF = 256;
    localparam int MAX_BINS_DEF   = 512;

    localparam int TABLE_DEPTH = 256;
    localparam int SUM_W       = 48;
    localparam int AMT_W       = 31;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 3;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_XORG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YORG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RLAST  = 3'd5;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_CLR  = 8'b0000_0010,
        ST_RD   = 8'b0000_0100,
        ST_ANG  = 8'b0000_1000,
        ST_MUL  = 8'b0001_0000,
        ST_POS  = 8'b0010_0000,
        ST_URD  = 8'b0100_0000,
        ST_UWR  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic              ok;
        logic [15:0]       bin;
        logic [AMT_W-1:0]  amount;
    } upd_t;

endpackage

// File: design/rpa_sample.sv
// One bin update of a quarter-pixel sample: position, bin, fraction and weight.
module rpa_sample #(
    parameter int MAX_BINS = rpa_pkg::MAX_BINS_DEF
) (
    input  logic signed [31:0] xc,
    input  logic signed [31:0] ys,
    input  logic signed [15:0] c,
    input  logic signed [15:0] s,
    input  logic [2:0]         sub,
    input  logic [15:0]        pixel,
    input  logic [7:0]         r_last,
    output rpa_pkg::upd_t      upd
);
    logic signed [31:0] c_term;
    logic signed [31:0] s_term;
    logic signed [31:0] pos;
    logic signed [15:0] bin;
    logic [15:0]        frac;
    logic [16:0]        weight;
    logic [32:0]        prod;

    always_comb
    begin
        c_term = sub[0] ? 32'(c) : -32'(c);
        s_term = sub[1] ? 32'(s) : -32'(s);
        pos    = xc + c_term + ys + s_term + $signed({7'd0, r_last, 17'd0});
        bin    = 16'(pos >>> 17) + {15'd0, sub[2]};
        frac   = pos[16:1];
        // upper bin takes frac, lower bin the rest
        weight = sub[2] ? {1'b0, frac} : 17'h10000 - {1'b0, frac};
        prod   = {17'd0, pixel} * {16'd0, weight};
        upd.amount = prod[32:2];
        upd.bin    = bin;
        upd.ok     = !bin[15] && (32'(bin) <= 32'({r_last, 1'b0}))
                     && (32'(bin) < MAX_BINS);
    end
endmodule

// File: design/radon_projection_accumulator_core.sv
// Top level of the pixel-driven Radon projection accumulator.
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | kind, angle_index, angle_cos, angle_sin,
//          |           |                       | pixel_row, pixel_col, pixel_value, bin_index
//  out     | output    | out_valid / out_stall | bin_sum, read_angle, read_bin
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
// Load items and skipped pixels are done in ST_IDLE; a read waits in ST_RD while
// the output stalls. A pixel runs ST_ANG and ST_MUL per angle in use to fetch and
// multiply, then eight bin updates, each a read, modify and write of the sum memory
// in ST_POS, ST_URD and ST_UWR (no ST_UWR when the bin is dropped).
// Clear and reset sweep the sum memory, one entry a cycle, over all MAX_ANGLES *
// 2^ceil(log2 MAX_BINS) entries (131072 by default); in_stall stays high meanwhile.
module radon_projection_accumulator_core #(
    parameter int MAX_ROWS   = rpa_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = rpa_pkg::MAX_COLS_DEF,
    parameter int MAX_ANGLES = rpa_pkg::MAX_ANGLES_DEF,
    parameter int MAX_BINS   = rpa_pkg::MAX_BINS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       kind,
    input  logic [7:0]                       angle_index,
    input  logic signed [15:0]               angle_cos,
    input  logic signed [15:0]               angle_sin,
    input  logic [7:0]                       pixel_row,
    input  logic [7:0]                       pixel_col,
    input  logic [15:0]                      pixel_value,
    input  logic [8:0]                       bin_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rpa_pkg::SUM_W-1:0]        bin_sum,
    output logic [7:0]                       read_angle,
    output logic [8:0]                       read_bin,
    input  logic                             cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpa_pkg::CFG_W-1:0]        cfg_data
);
    localparam int ANGLE_W   = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int ADDR_W    = ANGLE_W + BIN_W;
    localparam int MEM_DEPTH = MAX_ANGLES * (1 << BIN_W);
    localparam int SUM_W     = rpa_pkg::SUM_W;

    rpa_pkg::state_t state_reg, state_next;

    logic [8:0] rows_reg, cols_reg, angles_reg;
    logic [6:0] xorg_reg, yorg_reg;
    logic [7:0] rlast_reg;

    logic [15:0] cos_mem [rpa_pkg::TABLE_DEPTH];
    logic [15:0] sin_mem [rpa_pkg::TABLE_DEPTH];
    logic signed [15:0] cos_q_reg, sin_q_reg, c_reg, s_reg;

    logic [SUM_W-1:0] sum_mem [MEM_DEPTH];
    logic [SUM_W-1:0] rdata_reg;
    logic             mem_rd, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [SUM_W-1:0] mem_wdata;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [7:0]  k_reg;
    logic [2:0]  sub_reg;
    logic [8:0]  limit;
    logic signed [11:0] x4_reg, y4_reg;
    logic signed [31:0] xc_reg, ys_reg;
    logic [15:0] pixel_reg;
    logic [7:0]  rd_angle_reg;
    logic [8:0]  rd_bin_reg;
    logic        rd_ok_reg;
    rpa_pkg::upd_t upd_calc, upd_reg;

    logic        accept, skip, out_free, last_sub, last_angle;
    logic [SUM_W:0] sum_wide;
    logic signed [9:0] x_off, y_off;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != rpa_pkg::ST_IDLE);
    assign out_free = !out_valid || !out_stall;

    always_comb
    begin
        limit = angles_reg;
        if (32'(limit) > MAX_ANGLES)
        begin
            limit = 9'(MAX_ANGLES);
        end
        if (32'(limit) > rpa_pkg::TABLE_DEPTH)
        begin
            limit = 9'(rpa_pkg::TABLE_DEPTH);
        end
        skip = (pixel_value == 16'd0)
               || ({1'b0, pixel_row} >= rows_reg) || (32'(pixel_row) >= MAX_ROWS)
               || ({1'b0, pixel_col} >= cols_reg) || (32'(pixel_col) >= MAX_COLS)
               || (limit == 9'd0);
        x_off = $signed({2'b00, pixel_col}) - $signed({3'b000, xorg_reg});
        y_off = $signed({3'b000, yorg_reg}) - $signed({2'b00, pixel_row});
        last_sub   = (sub_reg == 3'd7);
        last_angle = ({1'b0, k_reg} + 9'd1 == limit);
        sum_wide   = {1'b0, rdata_reg} + {{(SUM_W - rpa_pkg::AMT_W + 1){1'b0}}, upd_reg.amount};
    end

    rpa_sample #(.MAX_BINS(MAX_BINS)) u_sample (
        .xc     (xc_reg),
        .ys     (ys_reg),
        .c      (c_reg),
        .s      (s_reg),
        .sub    (sub_reg),
        .pixel  (pixel_reg),
        .r_last (rlast_reg),
        .upd    (upd_calc)
    );

    always_comb
    begin
        state_next = state_reg;
        mem_rd     = 1'b0;
        mem_raddr  = {ANGLE_W'(k_reg), BIN_W'(upd_reg.bin)};
        mem_we     = 1'b0;
        mem_waddr  = {ANGLE_W'(k_reg), BIN_W'(upd_reg.bin)};
        mem_wdata  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        unique case (state_reg)
            rpa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        rpa_pkg::KIND_PIXEL: state_next = skip ? rpa_pkg::ST_IDLE
                                                               : rpa_pkg::ST_ANG;
                        rpa_pkg::KIND_READ:
                        begin
                            mem_rd     = 1'b1;
                            mem_raddr  = {ANGLE_W'(angle_index), BIN_W'(bin_index)};
                            state_next = rpa_pkg::ST_RD;
                        end
                        rpa_pkg::KIND_CLEAR: state_next = rpa_pkg::ST_CLR;
                        default:             state_next = rpa_pkg::ST_IDLE;
                    endcase
                end
            end
            rpa_pkg::ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (32'(clr_cnt_reg) == MEM_DEPTH - 1)
                begin
                    state_next = rpa_pkg::ST_IDLE;
                end
            end
            rpa_pkg::ST_RD:
            begin
                if (out_free)
                begin
                    state_next = rpa_pkg::ST_IDLE;
                end
            end
            rpa_pkg::ST_ANG: state_next = rpa_pkg::ST_MUL;
            rpa_pkg::ST_MUL: state_next = rpa_pkg::ST_POS;
            rpa_pkg::ST_POS: state_next = rpa_pkg::ST_URD;
            rpa_pkg::ST_URD:
            begin
                if (upd_reg.ok)
                begin
                    mem_rd     = 1'b1;
                    state_next = rpa_pkg::ST_UWR;
                end
                else if (!last_sub)
                begin
                    state_next = rpa_pkg::ST_POS;
                end
                else
                begin
                    state_next = last_angle ? rpa_pkg::ST_IDLE : rpa_pkg::ST_ANG;
                end
            end
            rpa_pkg::ST_UWR:
            begin
                mem_we = 1'b1;
                if (!last_sub)
                begin
                    state_next = rpa_pkg::ST_POS;
                end
                else
                begin
                    state_next = last_angle ? rpa_pkg::ST_IDLE : rpa_pkg::ST_ANG;
                end
            end
            default: state_next = rpa_pkg::ST_IDLE;
        endcase
    end

    // sum store and angle tables
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_rd)
        begin
            rdata_reg <= sum_mem[mem_raddr];
        end
        if (accept && kind == rpa_pkg::KIND_LOAD && 32'(angle_index) < MAX_ANGLES)
        begin
            cos_mem[angle_index] <= angle_cos;
            sin_mem[angle_index] <= angle_sin;
        end
        cos_q_reg <= cos_mem[k_reg];
        sin_q_reg <= sin_mem[k_reg];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x4_reg       <= {x_off, 2'b00};
            y4_reg       <= {y_off, 2'b00};
            pixel_reg    <= pixel_value;
            rd_angle_reg <= angle_index;
            rd_bin_reg   <= bin_index;
            rd_ok_reg    <= (32'(angle_index) < MAX_ANGLES) && (32'(bin_index) < MAX_BINS);
        end
        if (state_reg == rpa_pkg::ST_MUL)
        begin
            xc_reg <= 32'(x4_reg * cos_q_reg);
            ys_reg <= 32'(y4_reg * sin_q_reg);
            c_reg  <= cos_q_reg;
            s_reg  <= sin_q_reg;
        end
        if (state_reg == rpa_pkg::ST_POS)
        begin
            upd_reg <= upd_calc;
        end
        if (state_reg == rpa_pkg::ST_RD && out_free)
        begin
            bin_sum    <= rd_ok_reg ? rdata_reg : '0;
            read_angle <= rd_angle_reg;
            read_bin   <= rd_bin_reg;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rpa_pkg::ST_CLR;
            clr_cnt_reg <= '0;
            k_reg       <= '0;
            sub_reg     <= '0;
            out_valid   <= 1'b0;
            rows_reg    <= 9'd256;
            cols_reg    <= 9'd256;
            xorg_reg    <= 7'd127;
            yorg_reg    <= 7'd127;
            angles_reg  <= 9'd180;
            rlast_reg   <= 8'd182;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rpa_pkg::ST_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            else
            begin
                clr_cnt_reg <= '0;
            end
            if (state_reg == rpa_pkg::ST_IDLE)
            begin
                k_reg   <= '0;
                sub_reg <= '0;
            end
            else if ((state_reg == rpa_pkg::ST_URD && !upd_reg.ok)
                     || state_reg == rpa_pkg::ST_UWR)
            begin
                sub_reg <= sub_reg + 3'd1;
                if (last_sub)
                begin
                    k_reg <= k_reg + 8'd1;
                end
            end
            if (state_reg == rpa_pkg::ST_RD && out_free)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rpa_pkg::REG_ROWS:   rows_reg   <= cfg_data;
                    rpa_pkg::REG_COLS:   cols_reg   <= cfg_data;
                    rpa_pkg::REG_XORG:   xorg_reg   <= cfg_data[6:0];
                    rpa_pkg::REG_YORG:   yorg_reg   <= cfg_data[6:0];
                    rpa_pkg::REG_ANGLES: angles_reg <= cfg_data;
                    rpa_pkg::REG_RLAST:  rlast_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: design/rpa_checker.sv
// Port-level checks of the Radon projection accumulator, bound to its top level.
module rpa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  kind,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [rpa_pkg::SUM_W-1:0]   bin_sum,
    input logic [7:0]                  read_angle,
    input logic [8:0]                  read_bin
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(bin_sum) && $stable(read_angle)
                                   && $stable(read_bin))
        else $error("stalled result beat changed");

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> in_stall)
        else $error("input taken during clearing pass");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind != rpa_pkg::KIND_READ && !out_valid |=> !out_valid)
        else $error("result without a read");
endmodule

bind radon_projection_accumulator_core rpa_checker u_rpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .bin_sum    (bin_sum),
    .read_angle (read_angle),
    .read_bin   (read_bin)
);
